>>> hw/rtl/button_click_detector_top_macros.svh
// ---------------------------------------------------------------------------
// button click detector assertion macros
// concurrent check helpers clocked on clk_i with reset rst_ni
// ---------------------------------------------------------------------------
`ifndef BUTTON_CLICK_DETECTOR_TOP_MACROS_SVH
`define BUTTON_CLICK_DETECTOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

// antecedent and consequent in the same cycle
`define BCD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("button click detector check failed");

// consequent in the cycle after the antecedent
`define BCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("button click detector check failed");

`else

`define BCD_ASSERT_SAME(label, ante, cons)
`define BCD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> hw/rtl/bcd_pkg.sv
// ---------------------------------------------------------------------------
// button click detector package
// state, event and register codes shared by the detector
// ---------------------------------------------------------------------------
package bcd_pkg;

  // width of the stored start time and of the elapsed time
  parameter int unsigned TIME_BITS = 32;
  parameter int unsigned NOW_BITS  = 32;
  parameter int unsigned CFG_BITS  = 16;
  parameter int unsigned CNT_BITS  = 4;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_DOWN    = 3'd1,
    ST_UP      = 3'd2,
    ST_COUNT   = 3'd3,
    ST_LONG    = 3'd4,
    ST_LONGEND = 3'd5
  } state_e;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_CLICK_GAP  = 2'd2,
    REG_MAX_CLICKS = 2'd3
  } cfg_reg_e;

  parameter logic [CFG_BITS-1:0] DEBOUNCE_RST   = 16'd50;
  parameter logic [CFG_BITS-1:0] LONG_PRESS_RST = 16'd1000;
  parameter logic [CFG_BITS-1:0] CLICK_GAP_RST  = 16'd400;
  parameter logic [CNT_BITS-1:0] MAX_CLICKS_RST = 4'd2;

  parameter logic [CNT_BITS-1:0] CNT_MAX = 4'd15;
  parameter logic [CNT_BITS-1:0] CNT_ONE = 4'd1;
  parameter logic [CNT_BITS-1:0] CNT_TWO = 4'd2;

endpackage

>>> hw/rtl/button_click_detector_top.sv
// ---------------------------------------------------------------------------
// button click detector top level
// debounced single, double and long press detection on an active low pin
// ---------------------------------------------------------------------------
// path: an accepted request is held in the input register, then its result in the result register
// throughput: 1 request per cycle while out_stall_i is low, the state update between
//   the input register and the result register being combinational
// reset: asynchronous, active low; machine idle, start time and count zero,
//   registers back to debounce 50, long press 1000, click gap 400, max 2
`include "button_click_detector_top_macros.svh"

module button_click_detector_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            pin_level_i,
  input  logic [bcd_pkg::NOW_BITS-1:0]    now_ms_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      event_res_o,
  output logic [2:0]                      fsm_state_o,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_index_i,
  input  logic [bcd_pkg::CFG_BITS-1:0]    cfg_wdata_i
);

  // configuration registers
  logic [bcd_pkg::CFG_BITS-1:0] debounce_q, long_press_q, click_gap_q;
  logic [bcd_pkg::CNT_BITS-1:0] max_clicks_q;

  // input register stage
  logic                          s1_valid_q;
  logic                          s1_pin_q;
  logic [bcd_pkg::TIME_BITS-1:0] s1_now_q;

  // machine state
  bcd_pkg::state_e               cur_q, cur_d;
  bcd_pkg::state_e               prev_q, prev_d;
  logic [bcd_pkg::TIME_BITS-1:0] start_q, start_d;
  logic [bcd_pkg::CNT_BITS-1:0]  count_q, count_d;

  // result register
  logic                          out_valid_q;
  bcd_pkg::event_e               event_q, event_d;
  bcd_pkg::state_e               ostate_q;

  // handshake
  logic out_free;
  logic s1_adv;
  logic in_acc;

  // step terms
  logic                          pressed;
  logic                          released;
  logic [bcd_pkg::TIME_BITS-1:0] elapsed;
  logic                          in_debounce;
  logic                          past_long;
  logic                          past_gap;
  logic                          run_done;

  // result slot frees when empty or taken this cycle
  assign out_free = !out_valid_q || !out_stall_i;
  // the input stage moves on when its item can land in the result slot
  assign s1_adv   = s1_valid_q && out_free;
  // the input stage takes a request when empty or moving on
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // ---- configuration ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= bcd_pkg::DEBOUNCE_RST;
      long_press_q <= bcd_pkg::LONG_PRESS_RST;
      click_gap_q  <= bcd_pkg::CLICK_GAP_RST;
      max_clicks_q <= bcd_pkg::MAX_CLICKS_RST;
    end else if (cfg_we_i) begin
      unique case (bcd_pkg::cfg_reg_e'(cfg_index_i))
        bcd_pkg::REG_DEBOUNCE:   debounce_q   <= cfg_wdata_i;
        bcd_pkg::REG_LONG_PRESS: long_press_q <= cfg_wdata_i;
        bcd_pkg::REG_CLICK_GAP:  click_gap_q  <= cfg_wdata_i;
        bcd_pkg::REG_MAX_CLICKS: max_clicks_q <= cfg_wdata_i[bcd_pkg::CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---- input register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pin_q <= pin_level_i;
      s1_now_q <= bcd_pkg::TIME_BITS'(now_ms_i);
    end
  end

  // ---- step terms ----
  assign pressed  = !s1_pin_q;
  assign released = s1_pin_q;
  // wrapping time since the recorded start
  assign elapsed  = s1_now_q - start_q;

  assign in_debounce = elapsed < bcd_pkg::TIME_BITS'(debounce_q);
  assign past_long   = elapsed > bcd_pkg::TIME_BITS'(long_press_q);
  assign past_gap    = elapsed > bcd_pkg::TIME_BITS'(click_gap_q);
  assign run_done    = past_gap || (count_q == max_clicks_q);

  // ---- next state ----
  // a bounce swaps current and previous state; a run end returns both to
  // idle, and every other move shifts the current state into previous
  always_comb begin
    cur_d   = cur_q;
    prev_d  = prev_q;
    start_d = start_q;
    count_d = count_q;
    unique case (cur_q)
      bcd_pkg::ST_IDLE: begin
        if (pressed) begin
          cur_d   = bcd_pkg::ST_DOWN;
          prev_d  = cur_q;
          start_d = s1_now_q;
          count_d = '0;
        end
      end
      bcd_pkg::ST_DOWN: begin
        if (released && in_debounce) begin
          cur_d  = prev_q;
          prev_d = cur_q;
        end else if (released) begin
          cur_d   = bcd_pkg::ST_UP;
          prev_d  = cur_q;
          start_d = s1_now_q;
        end else if (past_long) begin
          cur_d  = bcd_pkg::ST_LONG;
          prev_d = cur_q;
        end
      end
      bcd_pkg::ST_UP: begin
        if (released && in_debounce) begin
          cur_d  = prev_q;
          prev_d = cur_q;
        end else if (!in_debounce) begin
          // count saturates
          if (count_q != bcd_pkg::CNT_MAX) begin
            count_d = count_q + 1'b1;
          end
          cur_d  = bcd_pkg::ST_COUNT;
          prev_d = cur_q;
        end
      end
      bcd_pkg::ST_COUNT: begin
        if (pressed) begin
          cur_d   = bcd_pkg::ST_DOWN;
          prev_d  = cur_q;
          start_d = s1_now_q;
        end else if (run_done) begin
          // run over, back to a clean idle
          cur_d   = bcd_pkg::ST_IDLE;
          prev_d  = bcd_pkg::ST_IDLE;
          start_d = '0;
          count_d = '0;
        end
      end
      bcd_pkg::ST_LONG: begin
        if (released) begin
          cur_d   = bcd_pkg::ST_LONGEND;
          prev_d  = cur_q;
          start_d = s1_now_q;
        end
      end
      bcd_pkg::ST_LONGEND: begin
        if (pressed && in_debounce) begin
          cur_d  = prev_q;
          prev_d = cur_q;
        end else if (!in_debounce) begin
          cur_d   = bcd_pkg::ST_IDLE;
          prev_d  = bcd_pkg::ST_IDLE;
          start_d = '0;
          count_d = '0;
        end
      end
      default: begin
        // unused codes fall back to idle
        cur_d  = bcd_pkg::ST_IDLE;
        prev_d = cur_q;
      end
    endcase
  end

  // ---- event output ----
  always_comb begin
    event_d = bcd_pkg::EV_NONE;
    unique case (cur_q)
      bcd_pkg::ST_COUNT: begin
        if (!pressed && run_done) begin
          if (count_q == bcd_pkg::CNT_ONE) begin
            event_d = bcd_pkg::EV_SINGLE;
          end else if (count_q == bcd_pkg::CNT_TWO) begin
            event_d = bcd_pkg::EV_DOUBLE;
          end
        end
      end
      bcd_pkg::ST_LONGEND: begin
        if (!(pressed && in_debounce) && !in_debounce) begin
          event_d = bcd_pkg::EV_LONG;
        end
      end
      default: event_d = bcd_pkg::EV_NONE;
    endcase
  end

  // ---- state registers, updated as each item leaves the input stage ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= bcd_pkg::ST_IDLE;
      prev_q  <= bcd_pkg::ST_IDLE;
      start_q <= '0;
      count_q <= '0;
    end else if (s1_adv) begin
      cur_q   <= cur_d;
      prev_q  <= prev_d;
      start_q <= start_d;
      count_q <= count_d;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      event_q  <= event_d;
      ostate_q <= cur_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = event_q;
  assign fsm_state_o = ostate_q;

  // ---- checks ----
  // an event always closes the run, so the reported state is idle
  `BCD_ASSERT_SAME(a_event_idle, out_valid_q && (event_q != bcd_pkg::EV_NONE), ostate_q == bcd_pkg::ST_IDLE)
  // an item leaving the input stage shows up as a result next cycle
  `BCD_ASSERT_NEXT(a_adv_result, s1_adv, out_valid_q)
  // idle with idle history only after reset or a clean run end, so nothing is left over
  `BCD_ASSERT_SAME(a_clean_idle, (cur_q == bcd_pkg::ST_IDLE) && (prev_q == bcd_pkg::ST_IDLE), (count_q == '0) && (start_q == '0))

endmodule
